// ----- hw/rtl/rbrd_pkg.sv -----
// shared types and constants for the byte run decoder
`default_nettype none

package rbrd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int WIDE_BITS  = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;
  localparam int CNT_BITS   = 7;

  localparam logic [WIDE_BITS-1:0] COUNTER_MAX   = WIDE_BITS'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic [SIZE_BITS-1:0] IMAGE_DEFAULT = SIZE_BITS'(1920);
  localparam int                   RUN_FLAG_BIT  = 7;

  typedef logic [7:0]            byte_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SIZE_BITS-1:0]  size_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_VALUE   = 3'b010,
    PH_LITERAL = 3'b100
  } phase_t;

  typedef struct packed {
    logic  valid;
    byte_t value;
    cnt_t  repeat_res;
    logic  last;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbrd_if.sv -----
// stream channel interfaces: compressed input, decoded results, size register
`default_nettype none

interface rbrd_code_if import rbrd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t code_byte;
  logic  start_of_image;
  modport source (output valid, output code_byte, output start_of_image, input ready);
  modport sink   (input valid, input code_byte, input start_of_image, output ready);
endinterface

interface rbrd_result_if import rbrd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t value;
  cnt_t  repeat_res;
  logic  last;
  modport source (output valid, output value, output repeat_res, output last, input ready);
  modport sink   (input valid, input value, input repeat_res, input last, output ready);
endinterface

interface rbrd_cfg_if import rbrd_pkg::*; ();
  logic  valid;
  logic  ready;
  size_t image_bytes;
  modport source (output valid, output image_bytes, input ready);
  modport sink   (input valid, input image_bytes, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rbrd_token_fsm.sv -----
// token state machine and byte counter, one compressed byte per step
`default_nettype none

module rbrd_token_fsm import rbrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  byte_t   code_byte,
  input  logic    start_of_image,
  input  size_t   image_bytes,
  output result_t result
);

  phase_t phase, phase_next;
  cnt_t   literal_left, literal_left_next;
  cnt_t   run_length, run_length_next;
  count_t bytes_written, bytes_written_next;

  phase_t                 ph_eff;
  cnt_t                   lit_eff, run_eff, lit_dec, rep;
  count_t                 bw_eff, lim, rem, bw_sum;
  logic [WIDE_BITS-1:0]   img_wide;
  logic                   below, end_tok, emit;

  always_comb begin
    img_wide = WIDE_BITS'(image_bytes);
    lim = (img_wide > COUNTER_MAX) ? COUNTER_MAX[COUNT_BITS-1:0]
                                   : img_wide[COUNT_BITS-1:0];

    // start flag clears the token state before this byte is looked at
    ph_eff  = start_of_image ? PH_HEADER : phase;
    lit_eff = start_of_image ? '0 : literal_left;
    run_eff = start_of_image ? '0 : run_length;
    bw_eff  = start_of_image ? '0 : bytes_written;

    below   = bw_eff < lim;
    rem     = lim - bw_eff;
    rep     = (COUNT_BITS'(run_eff) < rem) ? run_eff : rem[CNT_BITS-1:0];
    lit_dec = lit_eff - cnt_t'(1);

    phase_next        = ph_eff;
    literal_left_next = lit_eff;
    run_length_next   = run_eff;
    emit              = 1'b0;
    end_tok           = 1'b0;
    bw_sum            = bw_eff;
    result.value      = code_byte;
    result.repeat_res = cnt_t'(1);

    unique case (ph_eff)
      PH_VALUE: begin
        emit              = (run_eff != '0) && below;
        result.repeat_res = rep;
        if (emit) begin
          bw_sum = bw_eff + COUNT_BITS'(rep);
        end
        end_tok = 1'b1;
      end
      PH_LITERAL: begin
        emit = below;
        if (emit) begin
          bw_sum = bw_eff + COUNT_BITS'(1);
        end
        literal_left_next = lit_dec;
        end_tok           = (lit_dec == '0);
      end
      default: begin
        if (code_byte[RUN_FLAG_BIT]) begin
          run_length_next = code_byte[CNT_BITS-1:0];
          phase_next      = PH_VALUE;
        end else begin
          literal_left_next = code_byte[CNT_BITS-1:0];
          if (code_byte[CNT_BITS-1:0] == '0) begin
            end_tok = 1'b1;
          end else begin
            phase_next = PH_LITERAL;
          end
        end
      end
    endcase

    result.valid = emit;
    result.last  = bw_sum >= lim;

    bytes_written_next = bw_sum;
    if (end_tok) begin
      phase_next = PH_HEADER;
      if (bw_sum >= lim) begin
        bytes_written_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      literal_left  <= '0;
      run_length    <= '0;
      bytes_written <= '0;
    end else if (step) begin
      phase         <= phase_next;
      literal_left  <= literal_left_next;
      run_length    <= run_length_next;
      bytes_written <= bytes_written_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rle_byte_run_decoder.sv -----
// top level of the byte-oriented run-length decoder
`default_nettype none

// Decodes a byte run-length stream, one compressed byte per clock when neither
// side stalls. A header byte with bit 7 set is a run: its low seven bits are the
// count and the next byte is the value, given as one result with that repeat
// count. A header with bit 7 clear is followed by that many literal bytes, each
// given as a result with repeat 1. Headers and empty tokens (0x00, or 0x80 plus
// its value byte) give no result. A byte counter stops the image at the size in
// the image_bytes register (reset 1920): a run that reaches it is clipped, the
// result that reaches it is marked last, and bytes of the token beyond the end
// are swallowed. A new image begins after the token that completed the image,
// or at any byte carrying start_of_image. Every compressed byte passes an input
// register and then one step of the token state machine, which loads the result
// register; the state update that each byte needs is done in one step, so one
// byte per cycle is sustained when neither side stalls. The input stage keeps
// taking bytes while a result waits for the sink, until both registers are full.
// The size register takes a write every cycle and should only be written while
// the decoder is idle.

module rle_byte_run_decoder import rbrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  rbrd_code_if.sink     code,
  rbrd_result_if.source result,
  rbrd_cfg_if.sink      cfg
);

  // size register
  size_t image_bytes;

  // input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_sos;

  // result register
  logic  res_valid;
  byte_t res_value;
  cnt_t  res_repeat;
  logic  res_last;

  // state machine step and its result
  logic    step;
  result_t fsm_res;

  // advance the input byte whenever the result register is free or draining
  assign step       = in_valid && (!res_valid || result.ready);
  assign code.ready = !in_valid || step;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes <= IMAGE_DEFAULT;
    end else if (cfg.valid) begin
      image_bytes <= cfg.image_bytes;
    end
  end

  // input register: load on a transfer, empty when consumed with nothing behind
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (code.valid && code.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code.valid && code.ready) begin
      in_byte <= code.code_byte;
      in_sos  <= code.start_of_image;
    end
  end

  rbrd_token_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .code_byte      (in_byte),
    .start_of_image (in_sos),
    .image_bytes    (image_bytes),
    .result         (fsm_res)
  );

  // result register: a step that gives no result leaves it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= fsm_res.valid;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_value  <= fsm_res.value;
      res_repeat <= fsm_res.repeat_res;
      res_last   <= fsm_res.last;
    end
  end

  assign result.valid      = res_valid;
  assign result.value      = res_value;
  assign result.repeat_res = res_repeat;
  assign result.last       = res_last;

endmodule

`default_nettype wire
